/* rtl/nopf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nopf_pkg
// Shared types and constants of the n-th occurrence pattern finder.
// ----------------------------------------------------------------------------
package nopf_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PAT_W      = 64;
    localparam int unsigned PLEN_W     = 4;
    localparam int unsigned WANT_W     = 8;
    localparam int unsigned SEEN_W     = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PATTERN_BYTES     = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_LENGTH    = 2'd1;
    localparam t_cfg_idx CFG_OCCURRENCE_WANTED = 2'd2;

    // window control from the search controller
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage : nopf_pkg
`default_nettype wire

/* rtl/nopf_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nopf_matcher
// Byte window of recent bytes and the parallel compare with the pattern.
// ----------------------------------------------------------------------------
module nopf_matcher #(
    parameter int unsigned PATTERN_MAX = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire nopf_pkg::t_win_ctl            i_ctl,
    input  wire logic [7:0]                    i_byte,
    input  wire logic [nopf_pkg::PAT_W-1:0]    i_pattern,
    input  wire logic [nopf_pkg::PLEN_W-1:0]   i_len,
    output logic                               o_hit
);

    logic [7:0] r_win [PATTERN_MAX];
    logic [7:0] win_now [PATTERN_MAX];
    logic [PATTERN_MAX:1] hit_by_len;

    // window as it stands once this byte is in
    always_comb begin
        win_now[0] = i_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            win_now[j] = r_win[j-1];
        end
    end

    // pattern byte k against window entry L-1-k, for every length L
    always_comb begin
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            hit_by_len[l] = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (win_now[l-1-k] != i_pattern[8*k +: 8]) begin
                    hit_by_len[l] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_hit = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            if (i_len == nopf_pkg::PLEN_W'(l)) begin
                o_hit = hit_by_len[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= 8'd0;
            end
        end else if (i_ctl.shift) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= win_now[j];
            end
        end
    end

endmodule : nopf_matcher
`default_nettype wire

/* rtl/nth_occurrence_pattern_finder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nth_occurrence_pattern_finder
// Finds the start offset of the n-th (overlapping) occurrence of a byte
// pattern in a streamed buffer.
// ----------------------------------------------------------------------------
// One byte request is taken every cycle while the output is not stalled: a
// byte waits in the input register, then the window compare, occurrence
// count and answer logic settle combinationally into the result register.
// Each buffer gives exactly one result: found with the start offset of the
// wanted occurrence, or not-found when the last byte passes without it or
// the offset exceeds the position range. Bytes after the answer are dropped
// up to last_byte. The user must write configuration only while no buffer is
// in progress; the block itself does not enforce this.
module nth_occurrence_pattern_finder #(
    parameter int unsigned PATTERN_MAX   = 8,
    parameter int unsigned POSITION_BITS = 15
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nopf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nopf_pkg::PAT_W-1:0]        i_cfg_data,
    // byte stream
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_last_byte,
    // results
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_found,
    output logic [POSITION_BITS-1:0]               o_match_position
);

    localparam int unsigned SW = nopf_pkg::SEEN_W;
    localparam logic [SW-1:0] POS_MAX  = SW'((1 << POSITION_BITS) - 1);
    localparam logic [SW-1:0] SEEN_MAX = {SW{1'b1}};
    localparam logic [nopf_pkg::PLEN_W-1:0] LEN_MAX = nopf_pkg::PLEN_W'(PATTERN_MAX);

    logic [nopf_pkg::PAT_W-1:0]  r_pattern;
    logic [nopf_pkg::PLEN_W-1:0] r_plen;
    logic [nopf_pkg::WANT_W-1:0] r_want;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;

    logic [SW-1:0]                r_seen;
    logic [nopf_pkg::WANT_W-1:0]  r_count;
    logic                         r_answered;

    logic                     r_out_valid;
    logic                     r_found;
    logic [POSITION_BITS-1:0] r_pos;

    logic                         s1_go;
    logic                         work;
    logic [nopf_pkg::PLEN_W-1:0]  len_eff;
    logic                         cmp_hit;
    logic                         hit;
    logic [SW-1:0]                start;
    logic [nopf_pkg::WANT_W-1:0]  n_count;
    logic [SW-1:0]                n_seen;
    logic                         done_now;
    logic                         emit;
    logic                         emit_found;
    nopf_pkg::t_win_ctl           win_ctl;

    assign o_cfg_ready      = 1'b1;
    assign s1_go            = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready       = !r_s1_valid || s1_go;
    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_pos;

    assign work    = s1_go && !r_answered;
    assign len_eff = (r_plen > LEN_MAX) ? LEN_MAX : r_plen;

    assign win_ctl.shift = work;
    assign win_ctl.clear = s1_go && r_s1_last;

    nopf_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_byte    (r_s1_byte),
        .i_pattern (r_pattern),
        .i_len     (len_eff),
        .o_hit     (cmp_hit)
    );

    always_comb begin
        priority if (len_eff == '0) begin
            hit   = 1'b1;
            start = r_seen;
        end else if ((SW+1)'(r_seen) + (SW+1)'(1) >= (SW+1)'(len_eff)) begin
            hit   = cmp_hit;
            start = SW'((SW+1)'(r_seen) + (SW+1)'(1) - (SW+1)'(len_eff));
        end else begin
            hit   = 1'b0;
            start = '0;
        end
    end

    always_comb begin
        n_seen     = (r_seen != SEEN_MAX) ? r_seen + SW'(1) : r_seen;
        n_count    = r_count;
        if (hit && r_count != {nopf_pkg::WANT_W{1'b1}}) begin
            n_count = r_count + nopf_pkg::WANT_W'(1);
        end
        done_now   = hit && (r_want != '0) && (n_count == r_want);
        emit       = work && (done_now || r_s1_last);
        emit_found = done_now && (start <= POS_MAX);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= nopf_pkg::PLEN_W'(1);
            r_want    <= nopf_pkg::WANT_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nopf_pkg::CFG_PATTERN_BYTES: begin
                    r_pattern <= i_cfg_data;
                end
                nopf_pkg::CFG_PATTERN_LENGTH: begin
                    r_plen <= i_cfg_data[nopf_pkg::PLEN_W-1:0];
                end
                nopf_pkg::CFG_OCCURRENCE_WANTED: begin
                    r_want <= i_cfg_data[nopf_pkg::WANT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
        end
    end

    // per-buffer search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_go && r_s1_last)) begin
            r_seen     <= '0;
            r_count    <= '0;
            r_answered <= 1'b0;
        end else if (work) begin
            r_seen     <= n_seen;
            r_count    <= n_count;
            r_answered <= done_now;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_found <= emit_found;
            r_pos   <= emit_found ? start[POSITION_BITS-1:0] : '0;
        end
    end

endmodule : nth_occurrence_pattern_finder
`default_nettype wire

/* sim/tb_nth_occurrence_pattern_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nth_occurrence_pattern_finder
// Streams byte buffers into the pattern finder under a series of pattern,
// length and occurrence settings, tracks the search per byte in a
// scoreboard and checks every answer in order. Covers reset defaults,
// overlapping hits, short buffers, dense runs up to the 255th occurrence
// and output back-pressure.
// ----------------------------------------------------------------------------
module tb_nth_occurrence_pattern_finder;

    localparam int unsigned PATTERN_MAX   = 8;
    localparam int unsigned POSITION_BITS = 15;
    localparam int unsigned POS_MAX       = (1 << POSITION_BITS) - 1;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE        = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 1200;

    typedef struct packed {
        logic                     found;
        logic [POSITION_BITS-1:0] pos;
    } t_answer;

    class occurrence_tracker;
        logic [nopf_pkg::PAT_W-1:0]  pattern;
        logic [nopf_pkg::PLEN_W-1:0] pat_len;
        logic [nopf_pkg::WANT_W-1:0] wanted;
        logic [7:0]                  window [8];
        logic [nopf_pkg::SEEN_W-1:0] seen;
        logic [7:0]                  hits;
        bit                          answered;
        t_answer                     answers_due [$];
        int                          errors;

        function new();
            pattern = '0;
            pat_len = nopf_pkg::PLEN_W'(1);
            wanted  = nopf_pkg::WANT_W'(1);
            errors  = 0;
            new_buffer();
        endfunction

        function void new_buffer();
            foreach (window[k]) window[k] = 8'h00;
            seen     = '0;
            hits     = '0;
            answered = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned offs, len, start, k;
            bit          hit;
            t_answer     ans;
            if (!answered) begin
                offs = 32'(seen);
                for (k = 7; k > 0; k--) window[k] = window[k-1];
                window[0] = b;
                if (seen != '1) seen++;
                len   = (32'(pat_len) > PATTERN_MAX) ? PATTERN_MAX : 32'(pat_len);
                hit   = 1'b0;
                start = 0;
                if (len == 0) begin
                    hit   = 1'b1;
                    start = offs;
                end else if (offs + 1 >= len) begin
                    start = offs + 1 - len;
                    hit   = 1'b1;
                    for (k = 0; k < len; k++)
                        if (window[len-1-k] != pattern[8*k +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    if (hits != 8'hFF) hits++;
                    if (wanted != 0 && hits == wanted) begin
                        answered  = 1'b1;
                        ans.found = (start <= POS_MAX);
                        ans.pos   = ans.found ? POSITION_BITS'(start) : '0;
                        answers_due.push_back(ans);
                    end
                end
                if (last && !answered) begin
                    ans.found = 1'b0;
                    ans.pos   = '0;
                    answers_due.push_back(ans);
                end
            end
            if (last) new_buffer();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_answer(logic f, logic [POSITION_BITS-1:0] p);
            t_answer due;
            if (answers_due.size() == 0) begin
                flag($sformatf("unexpected result found=%0d pos=%0d", f, p));
                return;
            end
            due = answers_due.pop_front();
            if (f !== due.found || p !== due.pos)
                flag($sformatf("found exp %0d got %0d, pos exp %0d got %0d",
                               due.found, f, due.pos, p));
        endfunction
    endclass

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_cfg_valid      = 1'b0;
    logic                        o_cfg_ready;
    nopf_pkg::t_cfg_idx          i_cfg_index      = nopf_pkg::CFG_PATTERN_BYTES;
    logic [nopf_pkg::PAT_W-1:0]  i_cfg_data       = '0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_ready;
    logic [7:0]                  i_data_byte      = 8'h00;
    logic                        i_last_byte      = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready      = 1'b0;
    logic                        o_found;
    logic [POSITION_BITS-1:0]    o_match_position;

    occurrence_tracker tracker;
    logic [7:0]        stream_q [$];
    logic [7:0]        sym_a, sym_b;
    bit                tx_gaps     = 1'b0;
    bit                rx_gaps     = 1'b0;
    int                hold_asked  = 0;
    int                hold_taken  = 0;
    int                stall_left  = 0;
    int                cycles      = 0;
    int                bytes_sent  = 0;

    nth_occurrence_pattern_finder #(
        .PATTERN_MAX  (PATTERN_MAX),
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_match_position(o_match_position)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_nth_occurrence_pattern_finder: done, errors");
            $finish;
        end
    end

    // result side: random stalls plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken  <= hold_asked;
            stall_left  <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            stall_left  <= int'($urandom_range(0, 17));
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_answer(o_found, o_match_position);
    end

    task automatic write_reg(input nopf_pkg::t_cfg_idx idx,
                             input logic [nopf_pkg::PAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_search(input logic [nopf_pkg::PAT_W-1:0] pat,
                              input logic [nopf_pkg::PLEN_W-1:0] len,
                              input logic [nopf_pkg::WANT_W-1:0] want);
        write_reg(nopf_pkg::CFG_PATTERN_BYTES, pat);
        write_reg(nopf_pkg::CFG_PATTERN_LENGTH, nopf_pkg::PAT_W'(len));
        write_reg(nopf_pkg::CFG_OCCURRENCE_WANTED, nopf_pkg::PAT_W'(want));
        i_cfg_valid     <= 1'b0;
        tracker.pattern = pat;
        tracker.pat_len = len;
        tracker.wanted  = want;
    endtask

    // sends stream_q as one buffer, last flag on its final byte
    task automatic send_bytes();
        int i;
        for (i = 0; i < stream_q.size(); i++) begin
            if (tx_gaps && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_data_byte <= stream_q[i];
            i_last_byte <= (i == stream_q.size() - 1);
            do @(posedge i_clk); while (!o_in_ready);
            tracker.take_byte(stream_q[i], i == stream_q.size() - 1);
            bytes_sent++;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [nopf_pkg::PAT_W-1:0] rand_pattern(input int unsigned len);
        logic [nopf_pkg::PAT_W-1:0] pat;
        int unsigned                k, pick;
        pat = {$urandom, $urandom};
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                pat[8*k +: 8] = sym_a;
            else if (pick < 8)
                pat[8*k +: 8] = sym_b;
        end
        return pat;
    endfunction

    // mix of whole patterns, broken prefixes, alphabet bytes and noise
    task automatic fill_random(input int unsigned max_len);
        int unsigned n, k, cut;
        stream_q.delete();
        if (max_len <= 24 || $urandom_range(0, 4) != 0)
            n = $urandom_range(1, (max_len < 24) ? max_len : 24);
        else
            n = $urandom_range(1, max_len);
        while (stream_q.size() < n) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    cut = ($urandom_range(0, 2) == 0)
                          ? $urandom_range(1, 32'(tracker.pat_len))
                          : 32'(tracker.pat_len);
                    for (k = 0; k < cut && stream_q.size() < n; k++)
                        stream_q.push_back(tracker.pattern[8*k +: 8]);
                end
                9, 10, 11, 12:  stream_q.push_back(sym_a);
                13, 14, 15:     stream_q.push_back(sym_b);
                default:        stream_q.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic fill_run(input int unsigned n);
        stream_q.delete();
        repeat (n)
            stream_q.push_back(($urandom_range(0, 63) == 0) ? 8'($urandom) : sym_a);
    endtask

    initial begin
        int                          start_count, phase, phase_start, nbuf, run_len;
        bit                          late;
        logic [nopf_pkg::PLEN_W-1:0] len;
        logic [nopf_pkg::WANT_W-1:0] want;
        logic [nopf_pkg::PAT_W-1:0]  pat;

        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: single zero byte, first hit
        stream_q = '{8'h00, 8'hFF};
        send_bytes();
        stream_q = '{8'hFF};
        send_bytes();
        stream_q = '{8'h00};
        send_bytes();
        drain();

        set_search('1, 4'd8, 8'd1);
        stream_q.delete();
        repeat (7) stream_q.push_back(8'hFF);
        send_bytes();
        stream_q.delete();
        repeat (9) stream_q.push_back(8'hFF);
        send_bytes();
        drain();

        // overlapping hits
        set_search(64'h0123_4567_89AB_6161, 4'd2, 8'd3);
        stream_q = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h62};
        send_bytes();
        drain();

        start_count = bytes_sent;
        phase       = 0;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            late    = (bytes_sent - start_count) > RANDOM_ITEMS - 200;
            tx_gaps = !late && ($urandom_range(0, 3) != 0);
            rx_gaps <= !late && ($urandom_range(0, 3) != 0);
            sym_a   = 8'($urandom);
            sym_b   = 8'($urandom);
            phase_start = bytes_sent;
            if (phase == 2) begin
                // long output hold while short buffers keep coming
                tx_gaps = 1'b0;
                len     = nopf_pkg::PLEN_W'($urandom_range(1, 2));
                set_search(rand_pattern(32'(len)), len, 8'd1);
                hold_asked <= hold_asked + 1;
                while (bytes_sent - phase_start < 60) begin
                    fill_random(3);
                    send_bytes();
                end
            end else if (phase % 7 == 4) begin
                len  = nopf_pkg::PLEN_W'($urandom_range(1, 8));
                want = (phase == 4) ? 8'd255 : 8'($urandom_range(9, 60));
                pat  = {$urandom, $urandom};
                for (int k = 0; k < int'(len); k++) pat[8*k +: 8] = sym_a;
                set_search(pat, len, want);
                for (nbuf = 0; nbuf < 2; nbuf++) begin
                    run_len = int'(want) + int'(len) - 1 + int'($urandom_range(0, 6)) - 3;
                    fill_run((run_len < 1) ? 1 : run_len);
                    send_bytes();
                end
            end else begin
                case ($urandom_range(0, 3))
                    0:       len = ($urandom_range(0, 1) == 0) ? 4'd1 : 4'd8;
                    default: len = nopf_pkg::PLEN_W'($urandom_range(1, 8));
                endcase
                want = ($urandom_range(0, 2) == 0) ? 8'd1 : 8'($urandom_range(1, 5));
                set_search(rand_pattern(32'(len)), len, want);
                while (bytes_sent - phase_start < 50) begin
                    fill_random(120);
                    send_bytes();
                end
            end
            drain();
            phase++;
        end

        tx_gaps = 1'b0;
        drain();
        if (tracker.errors == 0 && tracker.answers_due.size() == 0)
            $display("tb_nth_occurrence_pattern_finder: done, clean");
        else
            $display("tb_nth_occurrence_pattern_finder: done, errors");
        $finish;
    end

endmodule
